// ===== hw/rtl/salru_pkg.sv =====
// shared types, codes and defaults of the set-associative lru cache tracker
package salru_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int FETCH_W    = 6;
    localparam int COPY_W     = 18;

    localparam int DEF_MAX_INDEX_BITS = 9;
    localparam int DEF_MAX_WAYS       = 8;
    localparam int DEF_ADDRESS_BITS   = 32;

    // item actions
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STORE = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;
    localparam logic [1:0] ACT_FLUSH = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_IDX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTR_IDX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_FLUSH,
        ST_FLUSH_LAST
    } t_state;

endpackage

// ===== hw/rtl/salru_ram.sv =====
// single write port, single read port set row memory with registered read data
module salru_ram
    import salru_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tracker.sv =====
// top level: tag-only set-associative true lru cache tracker with one shared way scanner
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  item in  | in        | start high, busy low       | i_action, i_address
//  result   | out       | o_valid, one cycle strobe  | o_miss, o_replaced, o_fetch_words,
//           |           |                            | o_copy_back_words,
//           |           |                            | o_counted_as_instruction
//  config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// an access item passes from acceptance to its result strobe through index, row read,
// a scan of one way per cycle through the shared tag and rank comparator, and update.
// a flush report reads one set row a cycle. after reset a clearing pass writes every
// row of the set memory, one a cycle, with busy high; configuration writes are taken
// meanwhile. the receiver cannot stall; a result shows for exactly one cycle.
module set_assoc_lru_cache_tracker
    import salru_pkg::*;
#(
    parameter int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS,
    parameter int MAX_WAYS       = DEF_MAX_WAYS,
    parameter int ADDRESS_BITS   = DEF_ADDRESS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_action,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_valid,
    output logic                  o_miss,
    output logic                  o_replaced,
    output logic [FETCH_W-1:0]    o_fetch_words,
    output logic [COPY_W-1:0]     o_copy_back_words,
    output logic                  o_counted_as_instruction,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // geometry
    localparam int SETS = 1 << MAX_INDEX_BITS;
    localparam int ROWS = 2 * SETS;
    localparam int RA   = MAX_INDEX_BITS + 1;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW   = WW;
    localparam int CW   = $clog2(MAX_WAYS + 1);
    localparam int EAW  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int TW   = EAW - 2;
    localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << EAW) - 64'd1);

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [RW-1:0] rank;
        logic [TW-1:0] tag;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // configuration registers
    logic       r_split;
    logic [3:0] r_data_ib;
    logic [3:0] r_instr_ib;
    logic [2:0] r_offset;
    logic [3:0] r_ways;
    logic       r_wb;
    logic       r_wa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split    <= 1'b0;
            r_data_ib  <= 4'd6;
            r_instr_ib <= 4'd6;
            r_offset   <= 3'd4;
            r_ways     <= 4'd1;
            r_wb       <= 1'b1;
            r_wa       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPLIT:       r_split    <= i_cfg_data[0];
                CFG_DATA_IDX:    r_data_ib  <= i_cfg_data;
                CFG_INSTR_IDX:   r_instr_ib <= i_cfg_data;
                CFG_OFFSET:      r_offset   <= i_cfg_data[2:0];
                CFG_WAYS:        r_ways     <= i_cfg_data;
                CFG_WRITE_BACK:  r_wb       <= i_cfg_data[0];
                CFG_WRITE_ALLOC: r_wa       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective configuration
    logic [2:0] eff_ob;
    logic [5:0] eff_ways;
    logic [5:0] words;

    assign eff_ob = (r_offset < 3'd2) ? 3'd2 : r_offset;
    assign words  = 6'd1 << (eff_ob - 3'd2);

    always_comb begin
        if (r_ways == 4'd0) begin
            eff_ways = 6'd1;
        end else if (32'(r_ways) > MAX_WAYS) begin
            eff_ways = 6'(MAX_WAYS);
        end else begin
            eff_ways = 6'(r_ways);
        end
    end

    // sequencer and datapath registers
    t_state r_state, n_state;
    logic [1:0]        r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [RA-1:0]     r_row;
    logic [TW-1:0]     r_tag;
    logic [RA-1:0]     r_cnt;
    logic [WW-1:0]     r_k;
    logic              r_hit_ok, r_free_ok, r_vic_ok;
    logic [WW-1:0]     r_hit, r_free, r_vic;
    logic [RW-1:0]     r_vic_rank;
    logic [CW-1:0]     r_count;
    logic              r_fpend;
    logic [COPY_W-1:0] r_acc;

    logic              r_o_valid;
    logic              r_o_miss, r_o_repl, r_o_instr;
    logic [FETCH_W-1:0] r_o_fetch;
    logic [COPY_W-1:0]  r_o_copy;

    // memory port
    logic             ram_we, ram_re;
    logic [RA-1:0]    ram_waddr, ram_raddr;
    t_row             ram_wdata;
    logic [ROW_W-1:0] ram_q;
    t_row             q_row;

    assign q_row = t_row'(ram_q);

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS),
        .AW    (RA)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ROW_W'(ram_wdata)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // index and tag from the held address
    logic              is_fetch, is_store, cache_sel;
    logic [3:0]        ib_raw;
    logic [3:0]        ib;
    logic [4:0]        tag_sh;
    logic [ADDR_W-1:0] eaddr, set_full;
    logic [RA-1:0]     row_calc;
    logic [TW-1:0]     tag_calc;

    assign is_fetch  = (r_action == ACT_FETCH);
    assign is_store  = (r_action == ACT_STORE);
    assign cache_sel = !is_fetch && r_split;
    assign ib_raw    = (is_fetch && r_split) ? r_instr_ib : r_data_ib;
    assign ib        = (32'(ib_raw) > MAX_INDEX_BITS) ? 4'(MAX_INDEX_BITS) : ib_raw;
    assign eaddr     = r_addr & AMASK;
    assign tag_sh    = 5'(eff_ob) + 5'(ib);
    assign set_full  = (eaddr >> eff_ob) & ~({ADDR_W{1'b1}} << ib);
    assign tag_calc  = TW'(eaddr >> tag_sh);
    assign row_calc  = RA'(set_full) + (cache_sel ? RA'(SETS) : RA'(0));

    // shared way scanner: one way of the set row per cycle
    t_way scan_way;
    assign scan_way = q_row[r_k];

    // update of a set row
    logic          full, miss_upd, no_alloc, use_hit;
    logic [WW-1:0] sel_w;
    logic          sel_was_valid;
    t_row          upd_row;
    logic [COPY_W-1:0] upd_copy;

    always_comb begin
        miss_upd      = !r_hit_ok;
        no_alloc      = miss_upd && is_store && !r_wa;
        full          = !((6'(r_count) < eff_ways) && r_free_ok);
        use_hit       = r_hit_ok;
        sel_w         = use_hit ? r_hit : (full ? r_vic : r_free);
        sel_was_valid = use_hit || full;
        upd_copy      = '0;
        upd_row       = q_row;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (WW'(k) != sel_w && q_row[k].valid &&
                (!sel_was_valid || q_row[k].rank < q_row[sel_w].rank)) begin
                upd_row[k].rank = q_row[k].rank + RW'(1);
            end
        end
        upd_row[sel_w].rank = '0;
        if (use_hit) begin
            if (is_store) begin
                if (r_wb) begin
                    upd_row[sel_w].dirty = 1'b1;
                end else begin
                    upd_copy = COPY_W'(1);
                end
            end
        end else if (no_alloc) begin
            upd_copy = COPY_W'(1);
        end else begin
            if (full && r_wb && q_row[sel_w].dirty) begin
                upd_copy = COPY_W'(words);
            end
            if (is_store && !r_wb) begin
                upd_copy = COPY_W'(1);
            end
            upd_row[sel_w].valid = 1'b1;
            upd_row[sel_w].tag   = r_tag;
            upd_row[sel_w].dirty = is_store && r_wb;
        end
    end

    // flush count of one row
    logic [COPY_W-1:0] row_dirty_words;
    logic [MAX_WAYS-1:0] dv_bits;

    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            dv_bits[k] = q_row[k].valid && q_row[k].dirty;
        end
        row_dirty_words = COPY_W'($countones(dv_bits)) << (eff_ob - 3'd2);
    end

    logic [RA-1:0] flush_row;
    assign flush_row = r_cnt + (r_split ? RA'(SETS) : RA'(0));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == RA'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_action == ACT_FLUSH) ? ST_FLUSH : ST_INDEX;
                end
            end
            ST_INDEX:  n_state = ST_READ;
            ST_READ:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_k == WW'(MAX_WAYS - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_FLUSH: begin
                if (r_cnt == RA'(SETS - 1)) begin
                    n_state = ST_FLUSH_LAST;
                end
            end
            ST_FLUSH_LAST: n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory control outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_row;
        ram_wdata = upd_row;
        ram_re    = 1'b0;
        ram_raddr = r_row;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
            end
            ST_READ:   ram_re = 1'b1;
            ST_UPDATE: ram_we = !no_alloc;
            ST_FLUSH: begin
                ram_re    = 1'b1;
                ram_raddr = flush_row;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            // result strobe follows the last cycle of an item
            r_o_valid <= (r_state == ST_UPDATE) || (r_state == ST_FLUSH_LAST);
            case (r_state)
                ST_CLEAR: r_cnt <= r_cnt + RA'(1);
                ST_IDLE:  r_cnt <= '0;
                ST_FLUSH: r_cnt <= r_cnt + RA'(1);
                default: ;
            endcase
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_action <= i_action;
                r_addr   <= i_address;
                r_fpend  <= 1'b0;
                r_acc    <= '0;
            end
            ST_INDEX: begin
                r_row <= row_calc;
                r_tag <= tag_calc;
            end
            ST_READ: begin
                r_k        <= '0;
                r_hit_ok   <= 1'b0;
                r_free_ok  <= 1'b0;
                r_vic_ok   <= 1'b0;
                r_count    <= '0;
                r_hit      <= '0;
                r_free     <= '0;
                r_vic      <= '0;
                r_vic_rank <= '0;
            end
            ST_SCAN: begin
                r_k <= r_k + WW'(1);
                if (!scan_way.valid) begin
                    if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_k;
                    end
                end else begin
                    r_count <= r_count + CW'(1);
                    if (!r_hit_ok && scan_way.tag == r_tag) begin
                        r_hit_ok <= 1'b1;
                        r_hit    <= r_k;
                    end
                    if (!r_vic_ok || scan_way.rank > r_vic_rank) begin
                        r_vic_ok   <= 1'b1;
                        r_vic      <= r_k;
                        r_vic_rank <= scan_way.rank;
                    end
                end
            end
            ST_UPDATE: begin
                r_o_miss  <= miss_upd;
                r_o_repl  <= miss_upd && !no_alloc && full;
                r_o_fetch <= (miss_upd && !no_alloc) ? words : '0;
                r_o_copy  <= upd_copy;
                r_o_instr <= is_fetch;
            end
            ST_FLUSH: begin
                r_fpend <= 1'b1;
                if (r_fpend && r_wb) begin
                    r_acc <= r_acc + row_dirty_words;
                end
            end
            ST_FLUSH_LAST: begin
                r_o_miss  <= 1'b0;
                r_o_repl  <= 1'b0;
                r_o_fetch <= '0;
                r_o_instr <= 1'b0;
                r_o_copy  <= r_wb ? (r_acc + row_dirty_words) : '0;
            end
            default: ;
        endcase
    end

    assign o_valid                  = r_o_valid;
    assign o_miss                   = r_o_miss;
    assign o_replaced               = r_o_repl;
    assign o_fetch_words            = r_o_fetch;
    assign o_copy_back_words        = r_o_copy;
    assign o_counted_as_instruction = r_o_instr;

    // checks
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without an item in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_repl_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_replaced) |-> o_miss)
        else $error("replacement reported on a hit");

    a_fetch_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fetch_words != '0) |-> o_miss)
        else $error("fetched words reported on a hit");

endmodule

// ===== bench/tb_set_assoc_lru_cache_tracker.sv =====
// self-checking testbench of the set-associative lru cache tracker
`timescale 1ns / 100ps

import salru_pkg::*;

typedef struct packed {
    logic               miss;
    logic               replaced;
    logic [FETCH_W-1:0] fetch_words;
    logic [COPY_W-1:0]  copy_back_words;
    logic               instr;
} t_access_outcome;

// predicts the outcome of each access and checks outcomes in order
class cache_scoreboard;
    localparam int IDX_MAX = DEF_MAX_INDEX_BITS;
    localparam int WAYS    = DEF_MAX_WAYS;
    localparam int LINES   = (2 << IDX_MAX) * WAYS;

    logic [31:0] line_tag[LINES];
    bit          line_vld[LINES];
    bit          line_drt[LINES];
    int          line_age[LINES];

    bit split_mode, wr_back, wr_alloc;
    int d_idx, i_idx, off_bits, way_cnt;

    t_access_outcome outcome_q[$];
    int errors;

    function new();
        for (int i = 0; i < LINES; i++) begin
            line_vld[i] = 0;
            line_drt[i] = 0;
            line_age[i] = 0;
        end
        split_mode = 0; d_idx = 6; i_idx = 6; off_bits = 4;
        way_cnt = 1; wr_back = 1; wr_alloc = 1;
        errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SPLIT:       split_mode = val[0];
            CFG_DATA_IDX:    d_idx = int'(val);
            CFG_INSTR_IDX:   i_idx = int'(val);
            CFG_OFFSET:      off_bits = int'(val[2:0]);
            CFG_WAYS:        way_cnt = int'(val);
            CFG_WRITE_BACK:  wr_back = val[0];
            CFG_WRITE_ALLOC: wr_alloc = val[0];
            default: ;
        endcase
    endfunction

    function int eff_off();
        return (off_bits < 2) ? 2 : off_bits;
    endfunction

    function int clip_idx(int v);
        return (v > IDX_MAX) ? IDX_MAX : v;
    endfunction

    // promote way w to most recent; valid lines more recent than w (all if w was empty) age by one
    function void promote(int base, int w, bit was_vld);
        for (int k = 0; k < WAYS; k++) begin
            if (k != w && line_vld[base + k])
                if (!was_vld || line_age[base + k] < line_age[base + w])
                    line_age[base + k]++;
        end
        line_age[base + w] = 0;
    endfunction

    function void lookup(int cache, int ib, logic [31:0] addr, logic [1:0] act,
                         ref t_access_outcome r);
        int ob, words, set_no, base, hit, free_w, victim, cnt, lim;
        logic [31:0] tag;
        ob = eff_off();
        words = 1 << (ob - 2);
        set_no = (addr >> ob) & ((1 << ib) - 1);
        tag = addr >> (ob + ib);
        base = ((cache << IDX_MAX) | set_no) * WAYS;
        hit = WAYS; free_w = WAYS; victim = WAYS; cnt = 0;
        lim = (way_cnt == 0) ? 1 : ((way_cnt > WAYS) ? WAYS : way_cnt);
        for (int k = 0; k < WAYS; k++) begin
            if (!line_vld[base + k]) begin
                if (free_w == WAYS) free_w = k;
            end else begin
                cnt++;
                if (hit == WAYS && line_tag[base + k] == tag) hit = k;
                if (victim == WAYS || line_age[base + k] > line_age[base + victim])
                    victim = k;
            end
        end
        if (hit != WAYS) begin
            if (act == ACT_STORE) begin
                if (wr_back) line_drt[base + hit] = 1;
                else r.copy_back_words = COPY_W'(1);
            end
            promote(base, hit, 1);
            return;
        end
        r.miss = 1;
        // store miss without allocation leaves the set alone
        if (act == ACT_STORE && !wr_alloc) begin
            r.copy_back_words = COPY_W'(1);
            return;
        end
        r.fetch_words = FETCH_W'(words);
        if (!(cnt < lim && free_w != WAYS)) begin
            r.replaced = 1;
            if (wr_back && line_drt[base + victim]) r.copy_back_words = COPY_W'(words);
            promote(base, victim, 1);
            free_w = victim;
        end else begin
            promote(base, free_w, 0);
        end
        line_vld[base + free_w] = 1;
        line_tag[base + free_w] = tag;
        line_drt[base + free_w] = (act == ACT_STORE) && wr_back;
        if (act == ACT_STORE && !wr_back) r.copy_back_words = COPY_W'(1);
    endfunction

    function void note_item(logic [1:0] act, logic [31:0] addr);
        t_access_outcome r;
        int sum, first;
        r = '0;
        if (act == ACT_FLUSH) begin
            sum = 0;
            if (wr_back) begin
                first = split_mode ? LINES / 2 : 0;
                for (int i = 0; i < LINES / 2; i++)
                    if (line_vld[first + i] && line_drt[first + i])
                        sum += 1 << (eff_off() - 2);
            end
            r.copy_back_words = COPY_W'(sum);
        end else if (act == ACT_FETCH) begin
            r.instr = 1;
            lookup(0, clip_idx(split_mode ? i_idx : d_idx), addr, act, r);
        end else begin
            lookup(split_mode ? 1 : 0, clip_idx(d_idx), addr, act, r);
        end
        outcome_q.push_back(r);
    endfunction

    function void check_result(t_access_outcome got);
        t_access_outcome exp;
        if (outcome_q.size() == 0) begin
            $display("%0t: result with nothing outstanding: %p", $time, got);
            errors++;
            return;
        end
        exp = outcome_q.pop_front();
        if (got.miss !== exp.miss) begin
            $display("%0t: miss exp %0d got %0d", $time, exp.miss, got.miss);
            errors++;
        end
        if (got.replaced !== exp.replaced) begin
            $display("%0t: replaced exp %0d got %0d", $time, exp.replaced, got.replaced);
            errors++;
        end
        if (got.fetch_words !== exp.fetch_words) begin
            $display("%0t: fetch_words exp %0d got %0d", $time,
                     exp.fetch_words, got.fetch_words);
            errors++;
        end
        if (got.copy_back_words !== exp.copy_back_words) begin
            $display("%0t: copy_back_words exp %0d got %0d", $time,
                     exp.copy_back_words, got.copy_back_words);
            errors++;
        end
        if (got.instr !== exp.instr) begin
            $display("%0t: counted_as_instruction exp %0d got %0d", $time,
                     exp.instr, got.instr);
            errors++;
        end
    endfunction
endclass

module tb_set_assoc_lru_cache_tracker;

    localparam int CYCLE_LIMIT = 4000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_action;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_valid;
    logic                  o_miss;
    logic                  o_replaced;
    logic [FETCH_W-1:0]    o_fetch_words;
    logic [COPY_W-1:0]     o_copy_back_words;
    logic                  o_counted_as_instruction;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cache_scoreboard sb;
    int              idle_pct;
    int              cycles = 0;
    logic [31:0]     addr_pool[16];

    set_assoc_lru_cache_tracker u_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .start                    (start),
        .busy                     (busy),
        .i_action                 (i_action),
        .i_address                (i_address),
        .o_valid                  (o_valid),
        .o_miss                   (o_miss),
        .o_replaced               (o_replaced),
        .o_fetch_words            (o_fetch_words),
        .o_copy_back_words        (o_copy_back_words),
        .o_counted_as_instruction (o_counted_as_instruction),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_idx                (i_cfg_idx),
        .i_cfg_data               (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // results cannot be held off, so every strobe is taken as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result({o_miss, o_replaced, o_fetch_words, o_copy_back_words,
                             o_counted_as_instruction});
    end

    // watchdog, sized well above the slowest correct run incl. the clearing pass
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one item: optional idle gap, then hold start until busy is low at an edge
    task automatic send_item(logic [1:0] act, logic [31:0] addr);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            i_action = 2'($urandom);
            i_address = $urandom;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_action = act;
        i_address = addr;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1;
                sb.note_item(act, addr);
            end
        end
    endtask

    // drain outstanding outcomes, then let the block settle before a write
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_all(int sp, int di, int ii, int ob, int wy, int wb, int wa);
        write_reg(CFG_SPLIT, CFG_DATA_W'(sp));
        write_reg(CFG_DATA_IDX, CFG_DATA_W'(di));
        write_reg(CFG_INSTR_IDX, CFG_DATA_W'(ii));
        write_reg(CFG_OFFSET, CFG_DATA_W'(ob));
        write_reg(CFG_WAYS, CFG_DATA_W'(wy));
        write_reg(CFG_WRITE_BACK, CFG_DATA_W'(wb));
        write_reg(CFG_WRITE_ALLOC, CFG_DATA_W'(wa));
    endtask

    // mostly addresses that collide in a handful of sets, some fully random
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 99) < 15) return $urandom;
        return addr_pool[$urandom_range(0, 15)] ^ ($urandom & 32'h3);
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return ACT_FLUSH;
        if (r < 28) return ACT_FETCH;
        if (r < 58) return ACT_STORE;
        return ACT_LOAD;
    endfunction

    initial begin
        sb = new();
        idle_pct = 31;
        start = 1'b0;
        i_action = ACT_LOAD;
        i_address = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SPLIT;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: hits, dirty eviction, flush, address extremes
        send_item(ACT_LOAD, 32'h0);
        send_item(ACT_LOAD, 32'h0);
        send_item(ACT_STORE, 32'h4);
        send_item(ACT_LOAD, 32'h400);
        send_item(ACT_STORE, 32'hFFFF_FFFF);
        send_item(ACT_FETCH, 32'hFFFF_FFFF);
        send_item(ACT_FLUSH, 32'h0);
        send_item(ACT_FETCH, 32'h0);
        drain();
        // write-through, no-allocate: store misses and hits
        write_reg(CFG_WRITE_BACK, 0);
        write_reg(CFG_WRITE_ALLOC, 0);
        send_item(ACT_STORE, 32'h1234_5670);
        send_item(ACT_LOAD, 32'h1234_5670);
        send_item(ACT_STORE, 32'h1234_5670);
        send_item(ACT_FLUSH, 32'hFFFF_FFFF);
        drain();
        // split caches, two ways, lines kept across the change
        set_all(1, 2, 3, 2, 2, 1, 1);
        send_item(ACT_FETCH, 32'h80);
        send_item(ACT_LOAD, 32'h80);
        send_item(ACT_STORE, 32'h180);
        send_item(ACT_STORE, 32'h280);
        send_item(ACT_LOAD, 32'h80);
        send_item(ACT_FLUSH, 32'h0);
        drain();
        write_reg(CFG_WAYS, 1);
        send_item(ACT_LOAD, 32'h380);
        send_item(ACT_FLUSH, 32'h0);

        // random phases: extremes first, then random settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: set_all(1, 0, 9, 2, 8, 1, 1);
                1: set_all(0, 15, 0, 7, 15, 0, 0);
                2: set_all(1, 1, 15, 0, 0, 1, 0);
                3: set_all(0, 9, 9, 1, 4, 1, 1);
                default: set_all($urandom_range(0, 1), $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom_range(0, 7),
                                 $urandom_range(0, 15), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
            endcase
            for (int k = 0; k < 16; k++)
                addr_pool[k] = ($urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h0)
                             | ($urandom_range(0, 7) << 13) | ($urandom_range(0, 7) << 7)
                             | ($urandom_range(0, 3) << 4);
            for (int n = 0; n < 190; n++) begin
                // sender idles 31 then 88 percent, then flat out
                idle_pct = (ph < 3) ? 31 : ((ph < 6) ? 88 : 0);
                if (n % 64 > 56) idle_pct = 0;
                send_item(pick_action(), pick_addr());
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.outcome_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
